/* src/dtrt_pkg.sv */
package dtrt_pkg;

    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_READ_DIV  = 3'd1,
        ACT_READ_CNT  = 3'd2,
        ACT_WRITE_CNT = 3'd3,
        ACT_RESET_DIV = 3'd4,
        ACT_WRITE_CTL = 3'd5,
        ACT_WRITE_MOD = 3'd6,
        ACT_NONE      = 3'd7
    } action_t;

    localparam int DIV_WIDTH      = 14;
    localparam int DIV_READ_SHIFT = 6;
    localparam int CTRL_ENABLE    = 2;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
        logic [7:0] counter_now;
    } result_t;

    // Low bits of the divider count that must be zero for the counter to step.
    function automatic logic [DIV_WIDTH-1:0] period_mask(input logic [1:0] sel);
        logic [DIV_WIDTH-1:0] mask;
        case (sel)
            2'd0:    mask = DIV_WIDTH'(14'h00FF);
            2'd1:    mask = DIV_WIDTH'(14'h0003);
            2'd2:    mask = DIV_WIDTH'(14'h000F);
            2'd3:    mask = DIV_WIDTH'(14'h003F);
            default: mask = DIV_WIDTH'(14'h00FF);
        endcase
        return mask;
    endfunction

endpackage

/* src/dtrt_core.sv */
module dtrt_core
    import dtrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [2:0] action,
    input  logic [7:0] data,
    output result_t    result
);

    logic [DIV_WIDTH-1:0] div_reg, div_next;
    logic [7:0]           cnt_reg, cnt_next;
    logic [7:0]           mod_reg, mod_next;
    logic [2:0]           ctl_reg, ctl_next;
    logic                 pend_reg, pend_next;
    logic [7:0]           rel_reg, rel_next;
    logic [DIV_WIDTH-1:0] div_inc;
    logic [7:0]           rd;
    logic                 irq;

    assign div_inc = div_reg + DIV_WIDTH'(1);

    always_comb
    begin
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        mod_next  = mod_reg;
        ctl_next  = ctl_reg;
        pend_next = pend_reg;
        rel_next  = rel_reg;
        rd        = 8'd0;
        irq       = 1'b0;
        case (action_t'(action))
            ACT_TICK:
            begin
                div_next = div_inc;
                if (ctl_reg[CTRL_ENABLE])
                begin
                    if (pend_reg)
                    begin
                        cnt_next  = rel_reg;
                        pend_next = 1'b0;
                    end
                    else if ((div_inc & period_mask(ctl_reg[1:0])) == '0)
                    begin
                        if (cnt_reg == 8'hFF)
                        begin
                            cnt_next  = 8'd0;
                            pend_next = 1'b1;
                            rel_next  = mod_reg;
                            irq       = 1'b1;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 8'd1;
                        end
                    end
                end
            end
            ACT_READ_DIV:  rd = div_reg[DIV_WIDTH-1:DIV_READ_SHIFT];
            ACT_READ_CNT:  rd = cnt_reg;
            ACT_WRITE_CNT:
            begin
                // A write is lost while the counter holds zero before its reload.
                if (!pend_reg)
                    cnt_next = data;
            end
            ACT_RESET_DIV: div_next = '0;
            ACT_WRITE_CTL:
            begin
                if (data[2:0] != ctl_reg)
                begin
                    if (!data[CTRL_ENABLE])
                        pend_next = 1'b0;
                    ctl_next = data[2:0];
                end
            end
            ACT_WRITE_MOD: mod_next = data;
            default: ;
        endcase
    end

    assign result.read_data   = rd;
    assign result.timer_irq   = irq;
    assign result.counter_now = cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg  <= '0;
            cnt_reg  <= '0;
            mod_reg  <= '0;
            ctl_reg  <= '0;
            pend_reg <= 1'b0;
            rel_reg  <= '0;
        end
        else if (step)
        begin
            div_reg  <= div_next;
            cnt_reg  <= cnt_next;
            mod_reg  <= mod_next;
            ctl_reg  <= ctl_next;
            pend_reg <= pend_next;
            rel_reg  <= rel_next;
        end
    end

endmodule

/* src/divider_tapped_reload_timer.sv */
// Divider-tapped timer with modulo reload.
// Input channel (in_valid/in_ready, action, data): each word is one machine
// tick or one register access (read divider, read counter, write counter,
// reset divider, write control, write modulo).
// Output channel (out_valid/out_ready, read_data, timer_irq, counter_now):
// exactly one word per input word, in order.
// The timer state updates at the accepting edge; the result word goes to the
// output register, or to the skid register while the output is stalled.
// Throughput is one word per cycle while the skid register is empty; all
// work is a single pass of short logic between the input ports and the output
// register. When the receiver stalls, one further result is parked in a skid
// register; in_ready drops only while that skid register is occupied.
// Reset clears all timer state (divider, counter, modulo, control, pending
// reload) and empties the output stage.
module divider_tapped_reload_timer
    import dtrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] action,
    input  logic [7:0] data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic       timer_irq,
    output logic [7:0] counter_now
);

    result_t res;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    push;
    logic    pop;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;
    assign pop      = out_valid_reg && out_ready;

    dtrt_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (push),
        .action (action),
        .data   (data),
        .result (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = out_reg.read_data;
    assign timer_irq   = out_reg.timer_irq;
    assign counter_now = out_reg.counter_now;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without an output word");

    a_irq_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.timer_irq) |->
            (out_reg.counter_now == 8'd0 && out_reg.read_data == 8'd0))
        else $error("overflow word must show a zero counter and no read data");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (!skid_valid_reg && out_valid_reg))
        else $error("skid word not moved to the output register");

endmodule

/* tb/tb.sv */
module tb
    import dtrt_pkg::*;
;

    // Tracks the timer state as words are accepted and holds the results still to come.
    class timer_scoreboard;
        logic [13:0] div_ticks;
        logic [7:0]  counter;
        logic [7:0]  modulo;
        logic [2:0]  ctl;
        bit          reload_due;
        logic [7:0]  reload_byte;
        result_t     awaited[$];
        int          mismatches;
        int          results_seen;
        int          overflows;
        int          tap_shift[4];

        function new();
            tap_shift = '{8, 2, 4, 6};
            div_ticks = '0;
            counter = '0;
            modulo = '0;
            ctl = '0;
            reload_due = 0;
            reload_byte = '0;
            mismatches = 0;
            results_seen = 0;
            overflows = 0;
        endfunction

        // One machine tick; returns the overflow flag.
        function bit advance_tick();
            logic [13:0] step_mask;
            div_ticks = div_ticks + 14'd1;
            if (!ctl[2])
                return 0;
            if (reload_due)
            begin
                counter = reload_byte;
                reload_due = 0;
                return 0;
            end
            step_mask = (14'd1 << tap_shift[ctl[1:0]]) - 14'd1;
            if ((div_ticks & step_mask) == '0)
            begin
                if (counter == 8'hFF)
                begin
                    counter = '0;
                    reload_due = 1;
                    reload_byte = modulo;
                    return 1;
                end
                counter = counter + 8'd1;
            end
            return 0;
        endfunction

        function void note_word(action_t act, logic [7:0] d);
            result_t r;
            r = '0;
            case (act)
                ACT_TICK:      r.timer_irq = advance_tick();
                ACT_READ_DIV:  r.read_data = div_ticks[13:6];
                ACT_READ_CNT:  r.read_data = counter;
                ACT_WRITE_CNT:
                begin
                    if (!reload_due)
                        counter = d;
                end
                ACT_RESET_DIV: div_ticks = '0;
                ACT_WRITE_CTL:
                begin
                    if (d[2:0] != ctl)
                    begin
                        if (!d[2])
                            reload_due = 0;
                        ctl = d[2:0];
                    end
                end
                ACT_WRITE_MOD: modulo = d;
                default: ;
            endcase
            r.counter_now = counter;
            if (r.timer_irq)
                overflows++;
            awaited.push_back(r);
        endfunction

        function void check_result(logic [7:0] rd, logic irq, logic [7:0] cnt);
            result_t e;
            results_seen++;
            if (awaited.size() == 0)
            begin
                $error("unexpected result word: read_data %0d timer_irq %0d counter_now %0d",
                       rd, irq, cnt);
                mismatches++;
                return;
            end
            e = awaited.pop_front();
            if (rd !== e.read_data)
            begin
                $error("read_data: expected %0d, got %0d", e.read_data, rd);
                mismatches++;
            end
            if (irq !== e.timer_irq)
            begin
                $error("timer_irq: expected %0d, got %0d", e.timer_irq, irq);
                mismatches++;
            end
            if (cnt !== e.counter_now)
            begin
                $error("counter_now: expected %0d, got %0d", e.counter_now, cnt);
                mismatches++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] action;
    logic [7:0] data;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] read_data;
    logic       timer_irq;
    logic [7:0] counter_now;

    timer_scoreboard sb;
    bit steady;
    int stall_left;
    int words_sent;

    divider_tapped_reload_timer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .data        (data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_data   (read_data),
        .timer_irq   (timer_irq),
        .counter_now (counter_now)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one, none while steady is set.
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    task automatic send_word(input action_t act, input logic [7:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        data <= d;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_word(act, d);
        words_sent++;
    endtask

    task automatic send_random_word();
        int r;
        logic [7:0] d;
        r = $urandom_range(0, 99);
        d = 8'($urandom_range(0, 255));
        if (r < 45)
            send_word(ACT_TICK, d);
        else if (r < 52)
            send_word(ACT_READ_DIV, d);
        else if (r < 60)
            send_word(ACT_READ_CNT, d);
        else if (r < 70)
        begin
            // Counter values near the top make overflows frequent.
            if ($urandom_range(0, 1) == 0)
                d = 8'($urandom_range(240, 255));
            send_word(ACT_WRITE_CNT, d);
        end
        else if (r < 73)
            send_word(ACT_RESET_DIV, d);
        else if (r < 83)
        begin
            if ($urandom_range(0, 4) != 0)
                d[2] = 1'b1;
            send_word(ACT_WRITE_CTL, d);
        end
        else if (r < 95)
            send_word(ACT_WRITE_MOD, d);
        else if (r < 98)
            send_word(ACT_NONE, d);
        else
            send_word(ACT_TICK, d);
    endtask

    // Result side: check every accepted word, then choose the next ready level.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_result(read_data, timer_irq, counter_now);
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (!steady && rst_n && $urandom_range(0, 99) < 30)
        begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                                      : $urandom_range(0, 2);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        #5_000_000;
        $display("divider_tapped_reload_timer regression: fail");
        $finish;
    end

    initial
    begin
        int i;
        sb = new();
        steady = 0;
        stall_left = 0;
        words_sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_TICK;
        data = '0;
        out_ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values, the unused action, and a stored write while disabled.
        send_word(ACT_READ_DIV, 8'h00);
        send_word(ACT_READ_CNT, 8'h00);
        send_word(ACT_NONE, 8'hFF);
        send_word(ACT_WRITE_MOD, 8'hAB);
        send_word(ACT_WRITE_CNT, 8'hFF);
        // Upper data bits of a control write are ignored.
        send_word(ACT_WRITE_CTL, 8'hFD);
        send_word(ACT_RESET_DIV, 8'h00);
        repeat (4) send_word(ACT_TICK, 8'h00);
        // The counter write during the hold is dropped, then the reload lands.
        send_word(ACT_WRITE_CNT, 8'h55);
        send_word(ACT_READ_CNT, 8'h00);
        send_word(ACT_TICK, 8'h00);
        send_word(ACT_WRITE_CTL, 8'h05);
        send_word(ACT_WRITE_CNT, 8'hFF);
        send_word(ACT_WRITE_MOD, 8'h00);
        repeat (4) send_word(ACT_TICK, 8'h00);
        // Disabling after the reload has landed; the next tick leaves the counter unchanged.
        send_word(ACT_WRITE_CTL, 8'h01);
        send_word(ACT_TICK, 8'h00);
        send_word(ACT_READ_CNT, 8'h00);

        // A run of back-to-back ticks with reads of the divider and no new receiver stalls.
        steady = 1;
        send_word(ACT_WRITE_CTL, 8'h04 | 8'($urandom_range(0, 3)));
        send_word(ACT_WRITE_MOD, 8'($urandom_range(0, 255)));
        for (i = 0; i < 200; i++)
        begin
            send_word(ACT_TICK, 8'($urandom_range(0, 255)));
            if ((i % 64) == 63)
                send_word(ACT_READ_DIV, 8'h00);
        end

        for (i = 0; i < 920; i++)
        begin
            if ((i % 100) == 0)
                steady = ($urandom_range(0, 3) == 0);
            send_random_word();
        end
        steady = 0;
        in_valid <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d words and checked %0d results, %0d of them overflows.",
                 words_sent, sb.results_seen, sb.overflows);
        $display("Covered all actions, holds, reloads, cancels and a back-to-back tick run.");
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("divider_tapped_reload_timer regression: pass");
        else
            $display("divider_tapped_reload_timer regression: fail");
        $finish;
    end

endmodule
